// ===== src/preset_position_bang_bang_controller_macros.svh =====
// assertion macros for the preset position bang-bang controller
// included by files that carry concurrent assertions; no other dependencies
`ifndef PRESET_POSITION_BANG_BANG_CONTROLLER_MACROS_SVH
`define PRESET_POSITION_BANG_BANG_CONTROLLER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PPBB_ASSERT_IMPL(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("ppbb assertion failed");
// next-cycle implication
`define PPBB_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("ppbb assertion failed");
`else
`define PPBB_ASSERT_IMPL(lbl, clk, rstn, pre, post)
`define PPBB_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

// ===== src/ppbb_pkg.sv =====
// shared types and constants of the preset position bang-bang controller
// used by the controller, the datapath and the top level; no dependencies
package ppbb_pkg;

  localparam int StickW  = 16;
  localparam int HeightW = 13;
  localparam int LevelW  = 4;
  localparam int SpeedW  = 15;
  localparam int StepW   = 10;
  localparam int TolW    = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 15;

  // restoring divide of |height| by level step, one quotient bit per cycle
  localparam int DivSteps = HeightW;
  localparam int DivCntW  = $clog2(DivSteps);

  // fixed mode target offset, 2 inches in 1/16 inch
  localparam int FixedOffset = 32;
  localparam int TargetW     = LevelW + StepW + 1;

  localparam logic [SpeedW-1:0] DriveSpeedRst = 15'd16384;
  localparam logic [StepW-1:0]  LevelStepRst  = 10'd194;
  localparam logic [TolW-1:0]   TolRst        = 8'd8;
  localparam logic [LevelW-1:0] MaxLevelRst   = 4'd6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDynamicMode = 3'd0,
    CfgFixedLevel  = 3'd1,
    CfgDriveSpeed  = 3'd2,
    CfgLevelStep   = 3'd3,
    CfgTolerance   = 3'd4,
    CfgMaxLevel    = 3'd5
  } cfg_index_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic level;
    logic write_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
  } sts_t;

endpackage

// ===== src/ppbb_ctrl.sv =====
// sequencing state machine of the preset position bang-bang controller
// depends on ppbb_pkg; drives the datapath through cmd_t, reads sts_t
module ppbb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  ppbb_pkg::sts_t sts_i,
  output ppbb_pkg::cmd_t cmd_o
);
  import ppbb_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StDiv   = 4'b0010,
    StLevel = 4'b0100,
    StBang  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = sts_i.need_div ? StDiv : StLevel;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = StLevel;
        end
      end
      StLevel: begin
        cmd_o.level = 1'b1;
        state_d     = StBang;
      end
      StBang: begin
        // hold the result until the output register is free
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o.write_out = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.write_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/ppbb_dp.sv =====
// datapath of the preset position bang-bang controller: settings, mode state,
// serial level divider, target multiply, band compare, result register; uses ppbb_pkg
module ppbb_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ppbb_pkg::cmd_t                        cmd_i,
  output ppbb_pkg::sts_t                        sts_o,
  input  logic                                  cfg_we_i,
  input  logic [ppbb_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [ppbb_pkg::CfgW-1:0]             cfg_data_i,
  input  logic signed [ppbb_pkg::StickW-1:0]    stick_y_i,
  input  logic                                  button_down_i,
  input  logic                                  button_up_i,
  input  logic signed [ppbb_pkg::HeightW-1:0]   height_i,
  output logic signed [ppbb_pkg::StickW-1:0]    drive_o,
  output logic                                  stop_o,
  output logic [ppbb_pkg::LevelW-1:0]           level_index_o,
  output logic                                  manual_active_o
);
  import ppbb_pkg::*;

  localparam int LvlW = HeightW + 2;
  localparam int CmpW = TargetW + 2;

  // settings
  logic              dyn_q;
  logic [LevelW-1:0] fixed_q;
  logic [SpeedW-1:0] speed_q;
  logic [StepW-1:0]  step_q;
  logic [TolW-1:0]   tol_q;
  logic [LevelW-1:0] max_q;

  // mode state
  logic              manual_q, prev_manual_q, prev_down_q, prev_up_q;
  logic [LevelW-1:0] current_q;

  // captured request
  logic signed [StickW-1:0]  stick_q;
  logic                      down_q, up_q;
  logic signed [HeightW-1:0] height_q;

  // divider
  logic [StepW-1:0]   rem_q;
  logic [HeightW-1:0] quo_q;
  logic [StepW+1:0]   trial;
  logic               trial_ok;

  logic              mf_in, mf_cap;
  logic [HeightW-1:0] height_mag;
  logic signed [LvlW-1:0] quo_signed, lvl_base, lvl_sum;
  logic              recapture, edge_down, edge_up;
  logic [LevelW-1:0] lvl_clamped, mult_a;
  logic [LevelW+StepW-1:0] product;
  logic [TargetW-1:0] target_d, target_q;

  logic signed [CmpW-1:0] h_ext, t_ext, tol_ext;
  logic                   below, above;
  logic signed [StickW-1:0] stick_neg, drive_d;
  logic                     stop_d, manual_d;

  // manual flag after a request, from given inputs and the stored flag
  function automatic logic manual_next(logic signed [StickW-1:0] stick, logic bd, logic bu,
                                       logic mf);
    logic r;
    r = mf;
    if (stick != '0) begin
      r = 1'b1;
    end else if (bd || bu) begin
      r = 1'b0;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dyn_q   <= 1'b1;
      fixed_q <= '0;
      speed_q <= DriveSpeedRst;
      step_q  <= LevelStepRst;
      tol_q   <= TolRst;
      max_q   <= MaxLevelRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDynamicMode: dyn_q   <= cfg_data_i[0];
        CfgFixedLevel:  fixed_q <= cfg_data_i[LevelW-1:0];
        CfgDriveSpeed:  speed_q <= cfg_data_i[SpeedW-1:0];
        CfgLevelStep:   step_q  <= cfg_data_i[StepW-1:0];
        CfgTolerance:   tol_q   <= cfg_data_i[TolW-1:0];
        CfgMaxLevel:    max_q   <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  assign mf_in      = manual_next(stick_y_i, button_down_i, button_up_i, manual_q);
  assign sts_o.need_div = dyn_q && !mf_in && prev_manual_q && (step_q != '0);
  assign height_mag = height_i[HeightW-1] ? HeightW'(-height_i) : HeightW'(height_i);

  assign trial    = {1'b0, rem_q, quo_q[HeightW-1]} - {2'b00, step_q};
  assign trial_ok = !trial[StepW+1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      stick_q  <= stick_y_i;
      down_q   <= button_down_i;
      up_q     <= button_up_i;
      height_q <= height_i;
      rem_q    <= '0;
      quo_q    <= height_mag;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ok ? trial[StepW-1:0] : {rem_q[StepW-2:0], quo_q[HeightW-1]};
      quo_q <= {quo_q[HeightW-2:0], trial_ok};
    end
  end

  // level selection on the captured request
  assign mf_cap     = manual_next(stick_q, down_q, up_q, manual_q);
  assign recapture  = prev_manual_q;
  assign edge_down  = down_q && !prev_down_q;
  assign edge_up    = up_q && !prev_up_q;
  assign quo_signed = height_q[HeightW-1] ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});

  always_comb begin
    if (recapture) begin
      lvl_base = (step_q != '0) ? quo_signed : '0;
    end else begin
      lvl_base = $signed({{(LvlW-LevelW){1'b0}}, current_q});
    end
    lvl_sum = lvl_base - $signed({{(LvlW-1){1'b0}}, edge_down})
                       + $signed({{(LvlW-1){1'b0}}, edge_up});
    if (lvl_sum < 0) begin
      lvl_clamped = '0;
    end else if (lvl_sum > $signed({{(LvlW-LevelW){1'b0}}, max_q})) begin
      lvl_clamped = max_q;
    end else begin
      lvl_clamped = lvl_sum[LevelW-1:0];
    end
  end

  assign mult_a   = dyn_q ? lvl_clamped : fixed_q;
  assign product  = mult_a * step_q;
  assign target_d = TargetW'(product) + (dyn_q ? TargetW'(0) : TargetW'(FixedOffset));

  always_ff @(posedge clk_i) begin
    if (cmd_i.level) begin
      target_q <= target_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      manual_q      <= 1'b1;
      prev_manual_q <= 1'b1;
      prev_down_q   <= 1'b0;
      prev_up_q     <= 1'b0;
      current_q     <= '0;
    end else if (cmd_i.level && dyn_q) begin
      manual_q      <= mf_cap;
      prev_manual_q <= mf_cap;
      prev_down_q   <= down_q;
      prev_up_q     <= up_q;
      if (!mf_cap) begin
        current_q <= lvl_clamped;
      end
    end
  end

  // stop band compare
  assign h_ext   = CmpW'(height_q);
  assign t_ext   = $signed({2'b00, target_q});
  assign tol_ext = $signed({{(CmpW-TolW){1'b0}}, tol_q});
  assign below   = (h_ext + tol_ext) < t_ext;
  assign above   = h_ext > (t_ext + tol_ext);

  assign stick_neg = (stick_q == {1'b1, {(StickW-1){1'b0}}}) ? {1'b0, {(StickW-1){1'b1}}}
                                                             : -stick_q;

  always_comb begin
    manual_d = dyn_q && manual_q;
    stop_d   = 1'b0;
    if (manual_d) begin
      drive_d = stick_neg;
    end else if (below) begin
      drive_d = $signed({1'b0, speed_q});
    end else if (above) begin
      drive_d = -$signed({1'b0, speed_q});
    end else begin
      drive_d = '0;
      stop_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_out) begin
      drive_o         <= drive_d;
      stop_o          <= stop_d;
      level_index_o   <= dyn_q ? current_q : fixed_q;
      manual_active_o <= manual_d;
    end
  end

endmodule

// ===== src/preset_position_bang_bang_controller.sv =====
// Preset position bang-bang height controller with a stop band.
// Request channel: stick_y_i, button_down_i, button_up_i, height_i with
// in_valid_i / in_stall_o; a request is taken when valid is high and stall low.
// Result channel: drive_o, stop_o, level_index_o, manual_active_o with
// out_valid_o / out_stall_i; exactly one result per request, in order.
// Settings are to be written through cfg_we_i / cfg_index_i / cfg_data_i only
// while idle, a duty of the user that the block does not enforce. A request
// runs the 13-step restoring divider (one quotient bit per cycle) only when
// the level is recaptured from the height on entering preset mode, then the
// level and bang states; the next request is taken only after the bang state.
// The result register frees the request side: the next request is taken while
// the previous result waits; a new result waits inside until that one is taken,
// and in_stall_o stays high meanwhile.
// Reset: settings return to their defaults, manual mode is selected, level 0,
// no result is held. Depends on ppbb_pkg, ppbb_ctrl, ppbb_dp and the macros.
`include "preset_position_bang_bang_controller_macros.svh"

module preset_position_bang_bang_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ppbb_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ppbb_pkg::CfgW-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [ppbb_pkg::StickW-1:0]  stick_y_i,
  input  logic                                button_down_i,
  input  logic                                button_up_i,
  input  logic signed [ppbb_pkg::HeightW-1:0] height_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ppbb_pkg::StickW-1:0]  drive_o,
  output logic                                stop_o,
  output logic [ppbb_pkg::LevelW-1:0]         level_index_o,
  output logic                                manual_active_o
);
  import ppbb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ppbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppbb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .stick_y_i       (stick_y_i),
    .button_down_i   (button_down_i),
    .button_up_i     (button_up_i),
    .height_i        (height_i),
    .drive_o         (drive_o),
    .stop_o          (stop_o),
    .level_index_o   (level_index_o),
    .manual_active_o (manual_active_o)
  );

  // a taken request keeps the block busy for at least the next cycle
  `PPBB_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // a new result never overwrites one still waiting
  `PPBB_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd.write_out, !(out_valid_o && out_stall_i))
  // a result write always leaves a valid result behind
  `PPBB_ASSERT_NEXT(a_result_valid, clk_i, rst_ni, cmd.write_out, out_valid_o)
  // commands are mutually exclusive
  `PPBB_ASSERT_IMPL(a_cmd_onehot, clk_i, rst_ni, 1'b1, $onehot0(cmd))

endmodule

// ===== dv/tb_preset_position_bang_bang_controller.sv =====
// self-checking testbench for the preset position bang-bang height controller
// predicts every result in-line and compares it field by field; needs ppbb_pkg
// and the controller RTL only
`timescale 1ns / 1ps

module tb_preset_position_bang_bang_controller;
  import ppbb_pkg::*;

  localparam int HalfPeriod     = 6;
  localparam int SettleCycles   = 24;
  localparam int CycleLimit     = 300000;
  localparam int RandomPerPhase = 65;
  localparam int FinalRequests  = 60;

  // indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  typedef struct packed {
    logic signed [StickW-1:0] drive;
    logic                     stop;
    logic [LevelW-1:0]        level;
    logic                     manual;
  } tick_result_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CfgIdxW-1:0]        cfg_index_i;
  logic [CfgW-1:0]           cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [StickW-1:0]  stick_y_i;
  logic                      button_down_i;
  logic                      button_up_i;
  logic signed [HeightW-1:0] height_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [StickW-1:0]  drive_o;
  logic                      stop_o;
  logic [LevelW-1:0]         level_index_o;
  logic                      manual_active_o;

  // shadow copy of the settings
  logic              sh_dynamic;
  logic [LevelW-1:0] sh_fixed_level;
  logic [SpeedW-1:0] sh_speed;
  logic [StepW-1:0]  sh_step;
  logic [TolW-1:0]   sh_tol;
  logic [LevelW-1:0] sh_max_level;

  // predicted controller state
  logic              manual_sel;
  logic              prev_manual_sel;
  logic              prev_down;
  logic              prev_up;
  logic [LevelW-1:0] sel_level;

  tick_result_t expected_ticks[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int cycles = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;

  preset_position_bang_bang_controller uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .stick_y_i      (stick_y_i),
    .button_down_i  (button_down_i),
    .button_up_i    (button_up_i),
    .height_i       (height_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_o        (drive_o),
    .stop_o         (stop_o),
    .level_index_o  (level_index_o),
    .manual_active_o(manual_active_o)
  );

  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  function automatic void band_drive(inout tick_result_t r, input int h, input int target);
    int tol;
    tol = int'(sh_tol);
    if (h < target - tol) begin
      r.drive = 16'(int'(sh_speed));
    end else if (h > target + tol) begin
      r.drive = 16'(-int'(sh_speed));
    end else begin
      r.drive = '0;
      r.stop  = 1'b1;
    end
  endfunction

  function automatic tick_result_t predict_tick(logic signed [StickW-1:0] stick, logic down,
                                                logic up, logic signed [HeightW-1:0] height);
    tick_result_t r;
    int stick_v;
    int h;
    int lvl;
    r = '0;
    stick_v = stick;
    h = height;
    if (sh_dynamic) begin
      if (stick_v != 0) begin
        manual_sel = 1'b1;
      end else if (down || up) begin
        manual_sel = 1'b0;
      end
      if (manual_sel) begin
        r.drive  = (stick_v == -32768) ? 16'sd32767 : 16'(-stick_v);
        r.manual = 1'b1;
      end else begin
        lvl = int'(sel_level);
        // recapture on the first preset tick, truncating toward zero
        if (prev_manual_sel) begin
          lvl = (sh_step != 0) ? h / int'(sh_step) : 0;
        end
        if (down && !prev_down) lvl--;
        if (up && !prev_up) lvl++;
        if (lvl < 0) lvl = 0;
        if (lvl > int'(sh_max_level)) lvl = int'(sh_max_level);
        sel_level = lvl[LevelW-1:0];
        band_drive(r, h, lvl * int'(sh_step));
      end
      // latches follow the buttons on every dynamic tick
      prev_manual_sel = manual_sel;
      prev_down = down;
      prev_up = up;
      r.level = sel_level;
    end else begin
      band_drive(r, h, int'(sh_fixed_level) * int'(sh_step) + FixedOffset);
      r.level = sh_fixed_level;
    end
    return r;
  endfunction

  task automatic send_tick(logic signed [StickW-1:0] stick, logic down, logic up,
                           logic signed [HeightW-1:0] height);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stick_y_i     <= stick;
    button_down_i <= down;
    button_up_i   <= up;
    height_i      <= height;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_ticks.push_back(predict_tick(stick, down, up, height));
    sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_ticks.size() != 0) @(posedge clk_i);
    // covers a recapture still running after the last result
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_setting(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgDynamicMode: sh_dynamic = value[0];
      CfgFixedLevel:  sh_fixed_level = value[LevelW-1:0];
      CfgDriveSpeed:  sh_speed = value[SpeedW-1:0];
      CfgLevelStep:   sh_step = value[StepW-1:0];
      CfgTolerance:   sh_tol = value[TolW-1:0];
      CfgMaxLevel:    sh_max_level = value[LevelW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // mostly preset sequences with heights around the current target
  task automatic send_random_tick();
    logic signed [StickW-1:0] stick;
    logic down;
    logic up;
    int h;
    int target;
    int pick;
    pick = $urandom_range(0, 99);
    stick = '0;
    down = ($urandom_range(0, 3) == 0);
    up = ($urandom_range(0, 3) == 0);
    target = sh_dynamic ? int'(sel_level) * int'(sh_step)
                        : int'(sh_fixed_level) * int'(sh_step) + FixedOffset;
    h = target + int'($urandom_range(0, 2 * int'(sh_tol) + 8)) - int'(sh_tol) - 4;
    if (pick < 15) begin
      stick = 16'($urandom);
    end else if (pick < 20) begin
      stick = pick[0] ? 16'sh8000 : 16'sh7fff;
    end else if (pick < 35) begin
      h = int'($urandom_range(0, 8191)) - 4096;
    end
    if (h > 4095) h = 4095;
    if (h < -4096) h = -4096;
    send_tick(stick, down, up, 13'(h));
  endtask

  task automatic run_phase(int count, logic dyn, logic [LevelW-1:0] fixed_lvl,
                           logic [SpeedW-1:0] speed, logic [StepW-1:0] step,
                           logic [TolW-1:0] tol, logic [LevelW-1:0] max_lvl);
    settle();
    // junk in the unused upper data bits
    write_setting(CfgDynamicMode, {14'($urandom), dyn});
    write_setting(CfgFixedLevel, {11'($urandom), fixed_lvl});
    write_setting(CfgDriveSpeed, speed);
    write_setting(CfgLevelStep, {5'($urandom), step});
    write_setting(CfgTolerance, {7'($urandom), tol});
    write_setting(CfgMaxLevel, {11'($urandom), max_lvl});
    repeat (count) send_random_tick();
  endtask

  task automatic test_manual_drive();
    send_tick(16'sd0, 1'b0, 1'b0, 13'sd0);
    send_tick(16'sh8000, 1'b0, 1'b0, 13'sd0);
    send_tick(16'sh7fff, 1'b0, 1'b0, 13'sd100);
    // buttons while manual only move the latches
    send_tick(16'sd1, 1'b1, 1'b1, 13'sd4095);
    send_tick(-16'sd1, 1'b0, 1'b0, 13'sd0);
  endtask

  task automatic test_preset_levels();
    send_tick(16'sd0, 1'b0, 1'b1, 13'sd400);
    send_tick(16'sd0, 1'b0, 1'b1, 13'sd582);
    // edges of the stop band around 582
    send_tick(16'sd0, 1'b0, 1'b0, 13'sd590);
    send_tick(16'sd0, 1'b0, 1'b0, 13'sd591);
    send_tick(16'sd0, 1'b0, 1'b0, 13'sd573);
    send_tick(16'sd0, 1'b1, 1'b0, 13'sd300);
    send_tick(16'sd0, 1'b0, 1'b0, 13'sd300);
    send_tick(16'sd0, 1'b1, 1'b1, 13'sd300);
    // recapture clamped at max, then at zero
    send_tick(16'sd100, 1'b0, 1'b0, 13'sd0);
    send_tick(16'sd0, 1'b0, 1'b1, 13'sd4095);
    send_tick(16'sd5, 1'b0, 1'b0, 13'sd0);
    send_tick(16'sd0, 1'b1, 1'b0, 13'sh1000);
    // negative height must truncate toward zero
    send_tick(-16'sd7, 1'b0, 1'b0, 13'sd0);
    send_tick(16'sd0, 1'b0, 1'b1, -13'sd193);
  endtask

  task automatic test_fixed_level();
    settle();
    write_setting(CfgDynamicMode, 15'd0);
    write_setting(CfgFixedLevel, 15'd15);
    write_setting(CfgLevelStep, 15'd1023);
    write_setting(CfgTolerance, 15'd0);
    send_tick(16'sd1234, 1'b1, 1'b1, 13'sd4095);
    settle();
    write_setting(CfgFixedLevel, 15'd0);
    write_setting(CfgLevelStep, 15'd1);
    write_setting(CfgDriveSpeed, 15'd32767);
    send_tick(16'sd0, 1'b0, 1'b0, 13'sd32);
    send_tick(16'sd0, 1'b0, 1'b0, 13'sd31);
    send_tick(16'sd0, 1'b0, 1'b0, 13'sd33);
  endtask

  task automatic test_zero_step();
    settle();
    write_setting(CfgLevelStep, 15'd0);
    write_setting(CfgFixedLevel, 15'd9);
    write_setting(CfgTolerance, 15'd255);
    send_tick(16'sd0, 1'b0, 1'b0, -13'sd223);
    settle();
    write_setting(CfgDynamicMode, 15'd1);
    send_tick(16'sd9, 1'b0, 1'b0, 13'sd0);
    send_tick(16'sd0, 1'b0, 1'b1, 13'sd3000);
  endtask

  task automatic test_spare_index();
    settle();
    write_setting(CfgSpareLo, 15'($urandom));
    write_setting(CfgSpareHi, 15'($urandom));
    send_tick(16'sd0, 1'b0, 1'b0, 13'sd50);
  endtask

  task automatic test_random_settings();
    sender_idle_pct = 30;
    stall_pct = 20;
    run_phase(RandomPerPhase, 1'b1, 4'd0, 15'd16384, 10'd194, 8'd8, 4'd6);
    run_phase(RandomPerPhase, 1'b1, 4'd15, 15'd32767, 10'd1, 8'd0, 4'd15);
    // a stretch with no idling on either side
    sender_idle_pct = 0;
    stall_pct = 0;
    run_phase(RandomPerPhase, 1'b1, 4'd0, 15'd0, 10'd1023, 8'd255, 4'd0);
    sender_idle_pct = 30;
    stall_pct = 20;
    run_phase(RandomPerPhase, 1'b0, 4'($urandom), 15'($urandom),
              10'($urandom_range(1, 1023)), 8'($urandom), 4'($urandom));
    run_phase(RandomPerPhase, 1'b1, 4'($urandom), 15'($urandom),
              10'($urandom_range(1, 200)), 8'($urandom_range(0, 40)), 4'($urandom));
    run_phase(RandomPerPhase, 1'($urandom), 4'($urandom), 15'($urandom),
              10'($urandom_range(1, 1023)), 8'($urandom), 4'($urandom));
  endtask

  task automatic test_back_to_back();
    sender_idle_pct = 0;
    stall_pct = 0;
    run_phase(FinalRequests, 1'b1, 4'($urandom), 15'($urandom),
              10'($urandom_range(1, 400)), 8'($urandom_range(0, 30)), 4'($urandom));
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_stall_i <= 1'b0;
    end else if (rst_ni && $urandom_range(0, 99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(1, 18);
    end
  end

  always @(posedge clk_i) begin : check_result
    tick_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_ticks.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want = expected_ticks.pop_front();
        checked++;
        if (drive_o !== want.drive) begin
          $error("drive: expected %0d, actual %0d", want.drive, drive_o);
          errors++;
        end
        if (stop_o !== want.stop) begin
          $error("stop: expected %0d, actual %0d", want.stop, stop_o);
          errors++;
        end
        if (level_index_o !== want.level) begin
          $error("level_index: expected %0d, actual %0d", want.level, level_index_o);
          errors++;
        end
        if (manual_active_o !== want.manual) begin
          $error("manual_active: expected %0d, actual %0d", want.manual, manual_active_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("run stopped after %0d cycles, %0d results outstanding",
               cycles, expected_ticks.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    stick_y_i     <= '0;
    button_down_i <= 1'b0;
    button_up_i   <= 1'b0;
    height_i      <= '0;
    out_stall_i   <= 1'b0;
    sh_dynamic      = 1'b1;
    sh_fixed_level  = '0;
    sh_speed        = DriveSpeedRst;
    sh_step         = LevelStepRst;
    sh_tol          = TolRst;
    sh_max_level    = MaxLevelRst;
    manual_sel      = 1'b1;
    prev_manual_sel = 1'b1;
    prev_down       = 1'b0;
    prev_up         = 1'b0;
    sel_level       = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 25;
    stall_pct = 15;
    test_manual_drive();
    test_preset_levels();
    test_fixed_level();
    test_zero_step();
    test_spare_index();
    test_random_settings();
    test_back_to_back();

    settle();
    if (expected_ticks.size() != 0) begin
      $error("%0d expected results never arrived", expected_ticks.size());
      errors++;
    end
    $display("covered %0d requests, %0d results checked: manual drive, recapture, stepping,",
             sent, checked);
    $display("fixed and zero-step targets, spare indexes, seven setting phases; %0d errors",
             errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ppbb_pkg.sv
src/ppbb_ctrl.sv
src/ppbb_dp.sv
src/preset_position_bang_bang_controller.sv
dv/tb_preset_position_bang_bang_controller.sv
